/* sv/txcw_pkg.sv */
// shared types and constants for the text console writer
package txcw_pkg;

  // default screen geometry
  localparam int unsigned ColumnsDef = 80;
  localparam int unsigned RowsDef    = 25;

  // character codes handled by the put command, and the default attribute used by clear
  localparam logic [7:0] CharBs      = 8'h08;
  localparam logic [7:0] CharLf      = 8'h0A;
  localparam logic [7:0] CharCr      = 8'h0D;
  localparam logic [7:0] CharSpace   = 8'h20;
  localparam logic [7:0] CharFirst   = 8'h20;
  localparam logic [7:0] CharLast    = 8'h7E;
  localparam logic [7:0] DefaultAttr = 8'h07;

  // command codes
  typedef enum logic [1:0] {
    CmdPut   = 2'd0,
    CmdClear = 2'd1,
    CmdRead  = 2'd2
  } txcw_cmd_e;

  // request payload
  typedef struct packed {
    logic [1:0] command;
    logic [7:0] char_code;
    logic [7:0] color;
    logic [4:0] read_row;
    logic [6:0] read_column;
  } txcw_req_t;

  // response payload
  typedef struct packed {
    logic [6:0]  cursor_column;
    logic [4:0]  cursor_row;
    logic [15:0] cell_value;
  } txcw_rsp_t;

endpackage

/* sv/text_console_writer_core.sv */
// text console writer: cell store, cursor and command sequencer
//
//  channel | direction | handshake                 | payload
//  req     | in        | req_valid_i / req_ready_o | req_i  (txcw_req_t)
//  rsp     | out       | rsp_valid_o / rsp_ready_i | rsp_o  (txcw_rsp_t)
//
// Before the response state, a printable put and a backspace away from column 0 pass
// the decode, address and write states; an in-range read passes decode, address,
// memory read and read data; an out-of-range read passes decode and address; carriage
// return, line feed without scroll and ignored codes pass decode only. Clear walks the
// store through the single write port. A scroll copies the store one cell per cycle
// through the read/write port pair and refills the bottom row.
// Reset clears cursor and control only; cells are undefined until a clear.
// Ready returns in the same cycle as the response is raised. A new request is taken
// while a finished response still waits on rsp_ready_i; the next finished response
// then holds the sequencer in its response state until the first one is taken.
module text_console_writer_core #(
  parameter int unsigned COLUMNS = txcw_pkg::ColumnsDef,
  parameter int unsigned ROWS    = txcw_pkg::RowsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                req_valid_i,
  output logic                req_ready_o,
  input  txcw_pkg::txcw_req_t req_i,
  output logic                rsp_valid_o,
  input  logic                rsp_ready_i,
  output txcw_pkg::txcw_rsp_t rsp_o
);
  import txcw_pkg::*;

  localparam int unsigned Cells = ROWS * COLUMNS;
  localparam int unsigned XW    = $clog2(COLUMNS);
  localparam int unsigned YW    = $clog2(ROWS);
  localparam int unsigned AW    = $clog2(Cells);

  localparam logic [XW-1:0] XLast     = XW'(COLUMNS - 1);
  localparam logic [YW-1:0] YLast     = YW'(ROWS - 1);
  localparam logic [AW-1:0] ColsA     = AW'(COLUMNS);
  localparam logic [AW-1:0] AddrLast  = AW'(Cells - 1);
  localparam logic [AW-1:0] BottomRow = AW'((ROWS - 1) * COLUMNS);

  // sequencer states
  localparam logic [3:0] StIdle   = 4'd0;
  localparam logic [3:0] StDecode = 4'd1;
  localparam logic [3:0] StAddr   = 4'd2;
  localparam logic [3:0] StWrite  = 4'd3;
  localparam logic [3:0] StRdMem  = 4'd4;
  localparam logic [3:0] StRdData = 4'd5;
  localparam logic [3:0] StScroll = 4'd6;
  localparam logic [3:0] StDrain  = 4'd7;
  localparam logic [3:0] StFill   = 4'd8;
  localparam logic [3:0] StClear  = 4'd9;
  localparam logic [3:0] StResp   = 4'd10;

  logic [3:0]    state_q, state_d;
  logic [XW-1:0] x_q, x_d;
  logic [YW-1:0] y_q, y_d;
  logic [AW-1:0] cnt_q, cnt_d;
  logic [AW-1:0] addr_q, addr_d;
  logic [AW-1:0] cp_addr_q, cp_addr_d;
  logic          cp_v_q, cp_v_d;
  logic [15:0]   cell_q, cell_d;
  txcw_req_t     item_q, item_d;
  logic          rsp_valid_q, rsp_valid_d;
  txcw_rsp_t     rsp_q, rsp_d;

  logic [15:0]   mem [Cells];
  logic [15:0]   rdata_q;
  logic          we;
  logic [AW-1:0] waddr;
  logic [AW-1:0] raddr;
  logic [15:0]   wdata;

  logic          is_print;
  logic          rd_in_range;

  assign req_ready_o = (state_q == StIdle);
  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

  assign is_print    = (item_q.char_code >= CharFirst) && (item_q.char_code <= CharLast);
  assign rd_in_range = (32'(item_q.read_row) < 32'(ROWS))
                    && (32'(item_q.read_column) < 32'(COLUMNS));

  // sequencer and cursor update
  always_comb begin
    state_d     = state_q;
    x_d         = x_q;
    y_d         = y_q;
    cnt_d       = cnt_q;
    addr_d      = addr_q;
    cp_addr_d   = cp_addr_q;
    cp_v_d      = 1'b0;
    cell_d      = cell_q;
    item_d      = item_q;
    rsp_valid_d = rsp_valid_q;
    rsp_d       = rsp_q;
    we          = 1'b0;
    waddr       = addr_q;
    wdata       = {item_q.color, CharSpace};
    raddr       = addr_q;

    if (rsp_valid_q && rsp_ready_i) begin
      rsp_valid_d = 1'b0;
    end

    unique case (state_q)
      StIdle: begin
        if (req_valid_i) begin
          item_d  = req_i;
          state_d = StDecode;
        end
      end
      StDecode: begin
        cell_d  = '0;
        state_d = StResp;
        case (item_q.command)
          CmdPut: begin
            if (item_q.char_code == CharBs) begin
              if (x_q != '0) begin
                x_d     = x_q - XW'(1);
                state_d = StAddr;
              end
            end else if (item_q.char_code == CharCr) begin
              x_d = '0;
            end else if (item_q.char_code == CharLf) begin
              x_d = '0;
              if (y_q == YLast) begin
                cnt_d   = ColsA;
                state_d = StScroll;
              end else begin
                y_d = y_q + YW'(1);
              end
            end else if (is_print) begin
              state_d = StAddr;
            end
          end
          CmdClear: begin
            x_d     = '0;
            y_d     = '0;
            cnt_d   = '0;
            state_d = StClear;
          end
          CmdRead: begin
            state_d = StAddr;
          end
          default: begin
            state_d = StResp;
          end
        endcase
      end
      StAddr: begin
        if (item_q.command == CmdRead) begin
          addr_d  = AW'(item_q.read_row) * ColsA + AW'(item_q.read_column);
          state_d = rd_in_range ? StRdMem : StResp;
        end else begin
          addr_d  = AW'(y_q) * ColsA + AW'(x_q);
          state_d = StWrite;
        end
      end
      StWrite: begin
        we      = 1'b1;
        wdata   = {item_q.color, (item_q.char_code == CharBs) ? CharSpace : item_q.char_code};
        state_d = StResp;
        if (item_q.char_code != CharBs) begin
          if (x_q == XLast) begin
            x_d = '0;
            if (y_q == YLast) begin
              cnt_d   = ColsA;
              state_d = StScroll;
            end else begin
              y_d = y_q + YW'(1);
            end
          end else begin
            x_d = x_q + XW'(1);
          end
        end
      end
      StRdMem: begin
        state_d = StRdData;
      end
      StRdData: begin
        cell_d  = rdata_q;
        state_d = StResp;
      end
      StScroll: begin
        raddr     = cnt_q;
        cp_v_d    = 1'b1;
        cp_addr_d = cnt_q - ColsA;
        if (cnt_q == AddrLast) begin
          state_d = StDrain;
        end else begin
          cnt_d = cnt_q + AW'(1);
        end
      end
      StDrain: begin
        cnt_d   = BottomRow;
        state_d = StFill;
      end
      StFill: begin
        we    = 1'b1;
        waddr = cnt_q;
        if (cnt_q == AddrLast) begin
          state_d = StResp;
        end else begin
          cnt_d = cnt_q + AW'(1);
        end
      end
      StClear: begin
        we    = 1'b1;
        waddr = cnt_q;
        wdata = {DefaultAttr, CharSpace};
        if (cnt_q == AddrLast) begin
          state_d = StResp;
        end else begin
          cnt_d = cnt_q + AW'(1);
        end
      end
      StResp: begin
        if (!rsp_valid_q || rsp_ready_i) begin
          rsp_valid_d         = 1'b1;
          rsp_d.cursor_column = 7'(x_q);
          rsp_d.cursor_row    = 5'(y_q);
          rsp_d.cell_value    = cell_q;
          state_d             = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase

    // delayed write side of the scroll copy
    if (cp_v_q) begin
      we    = 1'b1;
      waddr = cp_addr_q;
      wdata = rdata_q;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      x_q         <= '0;
      y_q         <= '0;
      cp_v_q      <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      x_q         <= x_d;
      y_q         <= y_d;
      cp_v_q      <= cp_v_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cnt_q     <= cnt_d;
    addr_q    <= addr_d;
    cp_addr_q <= cp_addr_d;
    cell_q    <= cell_d;
    item_q    <= item_d;
    rsp_q     <= rsp_d;
  end

  // cell store, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr];
  end

`ifndef ASSERT_OFF
  // cursor always stays on the screen
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (32'(x_q) < 32'(COLUMNS)) && (32'(y_q) < 32'(ROWS)))
    else $error("cursor left the screen");

  // an accepted request is decoded in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_valid_i && req_ready_o) |=> (state_q == StDecode))
    else $error("accepted request not decoded");

  // a response only appears out of the response state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_valid_q) |-> ($past(state_q) == StResp))
    else $error("response raised outside response state");

  // copy writes only happen while the scroll is running
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cp_v_q |-> (state_q == StScroll || state_q == StDrain))
    else $error("copy write outside scroll");

  // cursor does not move while the sequencer is idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StIdle) |=> ($stable(x_q) && $stable(y_q)))
    else $error("cursor changed while idle");
`endif

endmodule
